/* rtl/core/sdh_pkg.sv */
// Shared types and constants for the stick dead-band / hysteresis drive block.
package sdh_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int ONE_Q        = 1 << FRAC_BITS;
  localparam int VAL_W        = 16;
  localparam int LIM_W        = 15;
  localparam int PULSE_W      = 12;
  localparam int SPEED_W      = 8;
  localparam int CHAN_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int MOTOR_CH_MAX = 2;
  localparam int SERVO_CH_MAX = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int SPEED_GAIN   = 127;

  // shared multiplier: 17x17 signed
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CALC_W = 18;
  localparam int PSUM_W = 30;

  localparam logic [LIM_W-1:0]      AJ_RST        = LIM_W'(328);
  localparam logic [LIM_W-1:0]      LIM_MIN_RST   = '0;
  localparam logic [LIM_W-1:0]      LIM_MAX_RST   = LIM_W'(ONE_Q);
  localparam logic [CFG_DATA_W-1:0] PULSE_MIN_RST = 48'd68736258049000;
  localparam logic [CFG_DATA_W-1:0] PULSE_MAX_RST = 48'd137472516098000;

  typedef enum logic {
    CMD_MOTOR = 1'b0,
    CMD_SERVO = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANTI_JITTER = 3'd0,
    CFG_M0_LIM_MIN  = 3'd1,
    CFG_M0_LIM_MAX  = 3'd2,
    CFG_M1_LIM_MIN  = 3'd3,
    CFG_M1_LIM_MAX  = 3'd4,
    CFG_PULSE_MIN   = 3'd5,
    CFG_PULSE_MAX   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCALE,
    BK_FILT,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic                    command;
    logic [CHAN_W-1:0]       channel;
    logic signed [VAL_W-1:0] stick_value;
  } in_item_t;

  typedef struct packed {
    logic                      kind;
    logic [CHAN_W-1:0]         out_channel;
    logic signed [SPEED_W-1:0] motor_speed;
    logic [PULSE_W-1:0]        servo_pulse_us;
    logic signed [VAL_W-1:0]   filtered_value;
  } out_item_t;

  typedef struct packed {
    logic [LIM_W-1:0]                   anti_jitter;
    logic [MOTOR_CH_MAX-1:0][LIM_W-1:0] motor_lim_min;
    logic [MOTOR_CH_MAX-1:0][LIM_W-1:0] motor_lim_max;
    logic [CFG_DATA_W-1:0]              servo_pulse_min_table;
    logic [CFG_DATA_W-1:0]              servo_pulse_max_table;
  } cfg_regs_t;

  // one classified job handed from the front to the back
  typedef struct packed {
    logic                    kind;
    logic [CHAN_W-1:0]       channel;
    logic signed [VAL_W-1:0] stick;
    logic [LIM_W-1:0]        aj;
    logic [LIM_W-1:0]        lmin;
    logic [LIM_W-1:0]        lmax;
    logic [PULSE_W-1:0]      pmin;
    logic [PULSE_W-1:0]      pmax;
  } job_t;

endpackage

/* rtl/core/sdh_cfg.sv */
// Configuration register file for the stick drive block.
module sdh_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sdh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sdh_pkg::CFG_DATA_W-1:0]       cfg_data,
  output sdh_pkg::cfg_regs_t                   regs
);
  import sdh_pkg::*;

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.anti_jitter           <= AJ_RST;
      regs_r.motor_lim_min         <= {MOTOR_CH_MAX{LIM_MIN_RST}};
      regs_r.motor_lim_max         <= {MOTOR_CH_MAX{LIM_MAX_RST}};
      regs_r.servo_pulse_min_table <= PULSE_MIN_RST;
      regs_r.servo_pulse_max_table <= PULSE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANTI_JITTER: regs_r.anti_jitter      <= cfg_data[LIM_W-1:0];
        CFG_M0_LIM_MIN:  regs_r.motor_lim_min[0] <= cfg_data[LIM_W-1:0];
        CFG_M0_LIM_MAX:  regs_r.motor_lim_max[0] <= cfg_data[LIM_W-1:0];
        CFG_M1_LIM_MIN:  regs_r.motor_lim_min[1] <= cfg_data[LIM_W-1:0];
        CFG_M1_LIM_MAX:  regs_r.motor_lim_max[1] <= cfg_data[LIM_W-1:0];
        CFG_PULSE_MIN:   regs_r.servo_pulse_min_table <= cfg_data;
        CFG_PULSE_MAX:   regs_r.servo_pulse_max_table <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/sdh_front.sv */
// Front end: range check, stick clamp and per-channel limit selection.
module sdh_front #(
  parameter int MOTOR_CHANNELS = sdh_pkg::MOTOR_CH_MAX,
  parameter int SERVO_CHANNELS = sdh_pkg::SERVO_CH_MAX
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  sdh_pkg::in_item_t   in_data,
  input  sdh_pkg::cfg_regs_t  regs,
  input  logic                q_ready,
  output logic                q_push,
  output sdh_pkg::job_t       q_data
);
  import sdh_pkg::*;

  localparam int CMP_W = CHAN_W + 1;
  localparam logic signed [VAL_W-1:0] ONE_V   = VAL_W'(ONE_Q);
  localparam logic [LIM_W-1:0]        ONE_LIM = LIM_W'(ONE_Q);

  logic                    in_range;
  logic signed [VAL_W-1:0] v_clamp;
  logic [LIM_W-1:0]        raw_min;
  logic [LIM_W-1:0]        raw_max;
  logic [CMP_W-1:0]        chan_x;

  assign chan_x = {1'b0, in_data.channel};

  always_comb begin
    if (in_data.command == CMD_SERVO) begin
      in_range = chan_x < CMP_W'(SERVO_CHANNELS);
    end else begin
      in_range = chan_x < CMP_W'(MOTOR_CHANNELS);
    end
  end

  always_comb begin
    v_clamp = in_data.stick_value;
    if (in_data.stick_value < -ONE_V) begin
      v_clamp = -ONE_V;
    end
    if (in_data.stick_value > ONE_V) begin
      v_clamp = ONE_V;
    end
  end

  assign raw_min = regs.motor_lim_min[in_data.channel[0]];
  assign raw_max = regs.motor_lim_max[in_data.channel[0]];

  always_comb begin
    q_data.kind    = in_data.command;
    q_data.channel = in_data.channel;
    q_data.stick   = v_clamp;
    q_data.aj      = regs.anti_jitter;
    if (in_data.command == CMD_SERVO) begin
      q_data.lmin = '0;
      q_data.lmax = ONE_LIM;
    end else begin
      q_data.lmin = (raw_min > ONE_LIM) ? ONE_LIM : raw_min;
      q_data.lmax = (raw_max > ONE_LIM) ? ONE_LIM : raw_max;
    end
    q_data.pmin = regs.servo_pulse_min_table[PULSE_W*int'(in_data.channel) +: PULSE_W];
    q_data.pmax = regs.servo_pulse_max_table[PULSE_W*int'(in_data.channel) +: PULSE_W];
  end

  // out-of-range beats are taken and dropped
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && in_range;

endmodule

/* rtl/core/sdh_queue.sv */
// Small job queue between the front and back ends.
module sdh_queue #(
  parameter int DEPTH = sdh_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          ready,
  input  sdh_pkg::job_t wr_data,
  input  logic          pop,
  output logic          valid,
  output sdh_pkg::job_t rd_data
);
  import sdh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign ready   = count_r != CNT_W'(DEPTH);
  assign valid   = count_r != '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/sdh_back.sv */
// Back end: scaling, hysteresis filter, held values and result formatting.
module sdh_back #(
  parameter int MOTOR_CHANNELS = sdh_pkg::MOTOR_CH_MAX,
  parameter int SERVO_CHANNELS = sdh_pkg::SERVO_CH_MAX
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sdh_pkg::job_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sdh_pkg::out_item_t out_data
);
  import sdh_pkg::*;

  localparam int M_IDX_W = (MOTOR_CHANNELS > 1) ? $clog2(MOTOR_CHANNELS) : 1;
  localparam int S_IDX_W = (SERVO_CHANNELS > 1) ? $clog2(SERVO_CHANNELS) : 1;
  localparam logic signed [MUL_W-1:0] GAIN  = MUL_W'(SPEED_GAIN);
  localparam logic [PROD_W-1:0]       RND_Q = PROD_W'(ONE_Q - 1);
  localparam logic signed [VAL_W-1:0] ONE_V = VAL_W'(ONE_Q);

  bk_state_t state_r, state_nxt;
  job_t      job_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  held_r;
  logic signed [VAL_W-1:0]  motor_held_r [MOTOR_CHANNELS];
  logic signed [VAL_W-1:0]  servo_held_r [SERVO_CHANNELS];
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic                     job_load, prod_load, held_we, out_load;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  lim_span, pulse_span, stick_x, held_x;

  // filter datapath
  logic [PROD_W-1:0]        quot_adj;
  logic signed [CALC_W-1:0] quot, v_s, aj_s, lmin_s, lmax_s;
  logic signed [CALC_W-1:0] calc0, calc1, calc2, old_s, dlt, dlt_abs, calc_abs;
  logic signed [VAL_W-1:0]  old_held, held_new;

  // result datapath
  logic [PROD_W-1:0]        speed_adj;
  logic [PULSE_W:0]         pulse_sum;
  logic [PSUM_W-1:0]        pulse_base, psum;
  out_item_t                res;

  assign lim_span   = $signed({2'b00, job_r.lmax}) - $signed({2'b00, job_r.lmin});
  assign pulse_span = $signed({5'b0, job_r.pmax}) - $signed({5'b0, job_r.pmin});
  assign stick_x    = {job_r.stick[VAL_W-1], job_r.stick};
  assign held_x     = {held_r[VAL_W-1], held_r};
  assign prod       = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    job_load  = 1'b0;
    prod_load = 1'b0;
    held_we   = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          job_load  = 1'b1;
          state_nxt = BK_SCALE;
        end
      end
      BK_SCALE: begin
        mul_a     = lim_span;
        mul_b     = stick_x;
        prod_load = 1'b1;
        state_nxt = BK_FILT;
      end
      BK_FILT: begin
        held_we   = 1'b1;
        state_nxt = BK_OUT;
      end
      BK_OUT: begin
        mul_a = (job_r.kind == CMD_SERVO) ? pulse_span : GAIN;
        mul_b = held_x;
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    if (job_r.kind == CMD_SERVO) begin
      old_held = servo_held_r[job_r.channel[S_IDX_W-1:0]];
    end else begin
      old_held = motor_held_r[job_r.channel[M_IDX_W-1:0]];
    end
  end

  // dead zone and rescale, snap to the ends, then apply the hysteresis step
  always_comb begin
    quot_adj = prod_r + (prod_r[PROD_W-1] ? RND_Q : '0);
    quot     = $signed(quot_adj[FRAC_BITS +: CALC_W]);
    v_s      = $signed({{(CALC_W-VAL_W){job_r.stick[VAL_W-1]}}, job_r.stick});
    aj_s     = $signed({{(CALC_W-LIM_W){1'b0}}, job_r.aj});
    lmin_s   = $signed({{(CALC_W-LIM_W){1'b0}}, job_r.lmin});
    lmax_s   = $signed({{(CALC_W-LIM_W){1'b0}}, job_r.lmax});
    if (v_s > aj_s) begin
      calc0 = lmin_s + quot;
    end else if (v_s < -aj_s) begin
      calc0 = quot - lmin_s;
    end else begin
      calc0 = '0;
    end
    calc1    = (calc0 < aj_s - lmax_s) ? -lmax_s : calc0;
    calc2    = (calc1 > lmax_s - aj_s) ? lmax_s : calc1;
    old_s    = $signed({{(CALC_W-VAL_W){old_held[VAL_W-1]}}, old_held});
    dlt      = old_s - calc2;
    dlt_abs  = dlt[CALC_W-1] ? -dlt : dlt;
    calc_abs = calc2[CALC_W-1] ? -calc2 : calc2;
    held_new = (dlt_abs > aj_s) ? calc2[VAL_W-1:0] : old_held;
    if (calc_abs < aj_s) begin
      held_new = '0;
    end
  end

  always_comb begin
    speed_adj  = prod + (prod[PROD_W-1] ? RND_Q : '0);
    pulse_sum  = {1'b0, job_r.pmax} + {1'b0, job_r.pmin};
    pulse_base = {{(PSUM_W-PULSE_W-1-FRAC_BITS){1'b0}}, pulse_sum, {FRAC_BITS{1'b0}}};
    psum       = pulse_base + prod[PSUM_W-1:0];
    res.kind           = job_r.kind;
    res.out_channel    = job_r.channel;
    res.filtered_value = held_r;
    if (job_r.kind == CMD_SERVO) begin
      res.motor_speed    = '0;
      res.servo_pulse_us = psum[PSUM_W-1] ? '0 : psum[FRAC_BITS+1 +: PULSE_W];
    end else begin
      res.motor_speed    = $signed(speed_adj[FRAC_BITS +: SPEED_W]);
      res.servo_pulse_us = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      out_valid_r  <= 1'b0;
      motor_held_r <= '{default: '0};
      servo_held_r <= '{default: '0};
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (held_we) begin
        if (job_r.kind == CMD_SERVO) begin
          servo_held_r[job_r.channel[S_IDX_W-1:0]] <= held_new;
        end else begin
          motor_held_r[job_r.channel[M_IDX_W-1:0]] <= held_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= q_data;
    end
    if (prod_load) begin
      prod_r <= prod;
    end
    if (held_we) begin
      held_r <= held_new;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ap_job_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SCALE |=> state_r == BK_FILT ##1 state_r == BK_OUT)
    else $error("back end skipped a step of the job sequence");

  ap_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> !q_pop)
    else $error("queue popped while a job is in flight");

  ap_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.filtered_value <= ONE_V &&
                     out_data_r.filtered_value >= -ONE_V))
    else $error("filtered value outside plus or minus one");

  ap_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.kind == CMD_SERVO && out_data_r.motor_speed == '0) ||
                     (out_data_r.kind == CMD_MOTOR && out_data_r.servo_pulse_us == '0)))
    else $error("result carries a field of the other kind");

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_OUT && out_valid_r && !out_ready |=> state_r == BK_OUT)
    else $error("result overwritten while the receiver stalls");

endmodule

/* rtl/core/stick_deadband_hysteresis_drive_top.sv */
// Stick dead-band / hysteresis drive: top level.
//
// Input channel (in_valid/in_ready/in_data): one stick sample per beat, Q2.14,
// with a motor or servo command and a channel. A beat for a channel that does
// not exist is taken and dropped without a result.
// Output channel (out_valid/out_ready/out_data): one result per valid beat,
// carrying the held filtered value and either a motor speed or a servo pulse.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register
// writes, always ready; write only while the block is idle.
// Each accepted beat passes through the queue and then the back-end sequence
// (queue pop, scale multiply, filter update, result multiply), which shares a
// single 17x17 multiplier; the back end takes no new job until the result of
// the last one is loaded into the result register.
// A two-entry job queue decouples the front from the back; when the receiver
// stalls, the result register holds, the back end waits, the queue fills and
// in_ready drops.
// Reset restores the register defaults and clears every held value to zero.
module stick_deadband_hysteresis_drive_top #(
  parameter int MOTOR_CHANNELS = sdh_pkg::MOTOR_CH_MAX,
  parameter int SERVO_CHANNELS = sdh_pkg::SERVO_CH_MAX,
  parameter int Q_DEPTH        = sdh_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sdh_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sdh_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdh_pkg::*;

  cfg_regs_t regs;
  job_t      push_job, pop_job;
  logic      q_ready, q_push, q_valid, q_pop;

  sdh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  sdh_front #(
    .MOTOR_CHANNELS (MOTOR_CHANNELS),
    .SERVO_CHANNELS (SERVO_CHANNELS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .regs     (regs),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_data   (push_job)
  );

  sdh_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .ready   (q_ready),
    .wr_data (push_job),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (pop_job)
  );

  sdh_back #(
    .MOTOR_CHANNELS (MOTOR_CHANNELS),
    .SERVO_CHANNELS (SERVO_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* verif/sdh_drive_checker.sv */
`timescale 1ns / 100ps
// Result checker for the stick drive: watches all channels, predicts results, compares them.
module sdh_drive_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  sdh_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  sdh_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdh_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_total,
  output int                             awaiting
);
  import sdh_pkg::*;

  localparam longint UNIT            = longint'(ONE_Q);
  localparam longint DEAD_STEP_RESET = 328;
  localparam logic [CFG_DATA_W-1:0] PULSE_LO_RESET = {4{12'd1000}};
  localparam logic [CFG_DATA_W-1:0] PULSE_HI_RESET = {4{12'd2000}};

  longint                dead_step;
  longint                lim_lo     [MOTOR_CH_MAX];
  longint                lim_hi     [MOTOR_CH_MAX];
  logic [CFG_DATA_W-1:0] pulse_lo_tbl;
  logic [CFG_DATA_W-1:0] pulse_hi_tbl;
  longint                motor_hold [MOTOR_CH_MAX];
  longint                servo_hold [SERVO_CH_MAX];
  out_item_t             drive_results_due[$];
  int                    errs = 0;

  function automatic longint cap_at_unit(longint x);
    return (x > UNIT) ? UNIT : x;
  endfunction

  // dead zone, rescale into lo..hi, snap near the ends, then hysteresis on the held value
  function automatic longint hysteresis_update(longint held, longint sample, longint lo,
                                               longint hi);
    longint v;
    longint calc;
    longint diff;
    v = sample;
    if (v < -UNIT) v = -UNIT;
    if (v > UNIT) v = UNIT;
    calc = 0;
    if (v > dead_step) calc = lo + ((hi - lo) * v) / UNIT;
    if (v < -dead_step) calc = -lo + ((hi - lo) * v) / UNIT;
    if (calc < -hi + dead_step) calc = -hi;
    if (calc > hi - dead_step) calc = hi;
    diff = held - calc;
    if (diff < 0) diff = -diff;
    if (diff > dead_step) held = calc;
    if (calc < dead_step && calc > -dead_step) held = 0;
    return held;
  endfunction

  function automatic int field_differs(string field, logic signed [31:0] want,
                                       logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t rec;
    int        ch;
    longint    sample;
    longint    p_lo;
    longint    p_hi;
    longint    pulse;
    if (!rst_n) begin
      dead_step    = DEAD_STEP_RESET;
      pulse_lo_tbl = PULSE_LO_RESET;
      pulse_hi_tbl = PULSE_HI_RESET;
      for (int i = 0; i < MOTOR_CH_MAX; i++) begin
        lim_lo[i]     = 0;
        lim_hi[i]     = UNIT;
        motor_hold[i] = 0;
      end
      for (int i = 0; i < SERVO_CH_MAX; i++) servo_hold[i] = 0;
      drive_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ANTI_JITTER: dead_step    = longint'(cfg_data[LIM_W-1:0]);
          CFG_M0_LIM_MIN:  lim_lo[0]    = longint'(cfg_data[LIM_W-1:0]);
          CFG_M0_LIM_MAX:  lim_hi[0]    = longint'(cfg_data[LIM_W-1:0]);
          CFG_M1_LIM_MIN:  lim_lo[1]    = longint'(cfg_data[LIM_W-1:0]);
          CFG_M1_LIM_MAX:  lim_hi[1]    = longint'(cfg_data[LIM_W-1:0]);
          CFG_PULSE_MIN:   pulse_lo_tbl = cfg_data;
          CFG_PULSE_MAX:   pulse_hi_tbl = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (drive_results_due.size() == 0) begin
          $error("result beat with nothing expected: kind %0d channel %0d",
                 out_data.kind, out_data.out_channel);
          errs++;
        end else begin
          want = drive_results_due.pop_front();
          errs += field_differs("kind", want.kind, out_data.kind);
          errs += field_differs("out_channel", want.out_channel, out_data.out_channel);
          errs += field_differs("motor_speed", want.motor_speed, out_data.motor_speed);
          errs += field_differs("servo_pulse_us", want.servo_pulse_us,
                                out_data.servo_pulse_us);
          errs += field_differs("filtered_value", want.filtered_value,
                                out_data.filtered_value);
        end
      end

      if (in_valid && in_ready) begin
        rec             = '0;
        rec.kind        = in_data.command;
        rec.out_channel = in_data.channel;
        ch              = int'(in_data.channel);
        sample          = longint'($signed(in_data.stick_value));
        if (cmd_t'(in_data.command) == CMD_MOTOR) begin
          // nonexistent motor channels are swallowed
          if (ch < MOTOR_CH_MAX) begin
            motor_hold[ch] = hysteresis_update(motor_hold[ch], sample,
                                               cap_at_unit(lim_lo[ch]),
                                               cap_at_unit(lim_hi[ch]));
            rec.motor_speed    = SPEED_W'((motor_hold[ch] * SPEED_GAIN) / UNIT);
            rec.filtered_value = VAL_W'(motor_hold[ch]);
            drive_results_due.push_back(rec);
          end
        end else if (ch < SERVO_CH_MAX) begin
          servo_hold[ch] = hysteresis_update(servo_hold[ch], sample, 0, UNIT);
          p_lo  = longint'(pulse_lo_tbl[PULSE_W*ch +: PULSE_W]);
          p_hi  = longint'(pulse_hi_tbl[PULSE_W*ch +: PULSE_W]);
          pulse = ((p_hi + p_lo) * UNIT + (p_hi - p_lo) * servo_hold[ch]) / (2 * UNIT);
          if (pulse < 0) pulse = 0;
          rec.servo_pulse_us = PULSE_W'(pulse);
          rec.filtered_value = VAL_W'(servo_hold[ch]);
          drive_results_due.push_back(rec);
        end
      end
    end
    fail_total <= errs;
    awaiting   <= drive_results_due.size();
  end

endmodule

/* verif/stick_deadband_hysteresis_drive_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the stick drive: clock, reset, stimulus, stalls and the verdict.
module stick_deadband_hysteresis_drive_top_tb;
  import sdh_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LIM_TOP        = (1 << LIM_W) - 1;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  hold_req  = 1'b0;

  int fail_total;
  int awaiting;
  int burst_left   = 0;
  int aj_now       = 328;
  int quiet_cycles = 0;
  int prev_sample [2][4] = '{default: 0};

  always #6 clk = ~clk;

  stick_deadband_hysteresis_drive_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sdh_drive_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_total (fail_total),
    .awaiting   (awaiting)
  );

  // sender runs in bursts; valid stays up across back-to-back beats
  task automatic send_sample(input cmd_t cmd, input int ch, input int value);
    in_item_t beat;
    int       gap;
    beat.command     = cmd;
    beat.channel     = ch[CHAN_W-1:0];
    beat.stick_value = value[VAL_W-1:0];
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait out all results, then let the block drain with no input
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pulse_table(input int lo, input int hi);
    logic [CFG_DATA_W-1:0] t;
    for (int i = 0; i < 4; i++) t[PULSE_W*i +: PULSE_W] = PULSE_W'($urandom_range(lo, hi));
    return t;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return ONE_Q;
      default: return LIM_TOP;
    endcase
  endfunction

  // style 0: realistic, 1: wide random with junk above the field, 2: extremes
  task automatic settle_config(input int style);
    int                    lim [4];
    logic [32:0]           upper;
    logic [CFG_DATA_W-1:0] lo_tbl;
    logic [CFG_DATA_W-1:0] hi_tbl;
    upper = '0;
    case (style)
      0: begin
        aj_now = $urandom_range(0, 800);
        lim[0] = $urandom_range(0, 6000);
        lim[1] = $urandom_range(10000, ONE_Q);
        lim[2] = $urandom_range(0, 6000);
        lim[3] = $urandom_range(10000, ONE_Q);
        lo_tbl = pulse_table(500, 1500);
        hi_tbl = pulse_table(1500, 2500);
      end
      1: begin
        upper  = 33'($urandom());
        aj_now = $urandom_range(0, ONE_Q);
        for (int i = 0; i < 4; i++) lim[i] = $urandom_range(0, LIM_TOP);
        lo_tbl = {16'($urandom()), 32'($urandom())};
        hi_tbl = {16'($urandom()), 32'($urandom())};
      end
      default: begin
        aj_now = ($urandom_range(0, 1) == 0) ? 0 : ONE_Q;
        for (int i = 0; i < 4; i++) lim[i] = pick_extreme();
        lo_tbl = ($urandom_range(0, 1) == 0) ? '0 : '1;
        hi_tbl = ($urandom_range(0, 1) == 0) ? '1 : pulse_table(0, 4095);
      end
    endcase
    program_reg(CFG_ANTI_JITTER, {upper, LIM_W'(aj_now)});
    program_reg(CFG_M0_LIM_MIN,  {upper, LIM_W'(lim[0])});
    program_reg(CFG_M0_LIM_MAX,  {upper, LIM_W'(lim[1])});
    program_reg(CFG_M1_LIM_MIN,  {upper, LIM_W'(lim[2])});
    program_reg(CFG_M1_LIM_MAX,  {upper, LIM_W'(lim[3])});
    program_reg(CFG_PULSE_MIN,   lo_tbl);
    program_reg(CFG_PULSE_MAX,   hi_tbl);
    cfg_valid <= 1'b0;
  endtask

  // mostly small steps around each channel's last sample so hysteresis gets exercised
  task automatic random_phase(input int count);
    int   done;
    int   roll;
    int   ch;
    int   value;
    int   span;
    int   boundary [10];
    cmd_t cmd;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      cmd  = cmd_t'($urandom_range(0, 1));
      if (roll < 8) begin
        send_sample(CMD_MOTOR, $urandom_range(2, 3), $signed(16'($urandom())));
        continue;
      end
      ch = (cmd == CMD_MOTOR) ? $urandom_range(0, 1) : $urandom_range(0, 3);
      if (roll < 70) begin
        span  = 2 * aj_now + 64;
        value = prev_sample[cmd][ch] + int'($urandom_range(0, 2 * span)) - span;
      end else if (roll < 85) begin
        value = $signed(16'($urandom()));
      end else begin
        boundary = '{aj_now, -aj_now, aj_now + 1, -aj_now - 1, ONE_Q, -ONE_Q,
                     ONE_Q - 1, -ONE_Q + 1, 32767, -32768};
        value = boundary[$urandom_range(0, 9)];
      end
      if (value > 32767) value = 32767;
      if (value < -32768) value = -32768;
      send_sample(cmd, ch, value);
      prev_sample[cmd][ch] = value;
      done++;
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: clamping, dead zone edge, hysteresis hold, snap to the ends
    send_sample(CMD_MOTOR, 0, 32767);
    send_sample(CMD_MOTOR, 0, -32768);
    send_sample(CMD_MOTOR, 0, 0);
    send_sample(CMD_MOTOR, 0, 328);
    send_sample(CMD_MOTOR, 0, 329);
    send_sample(CMD_MOTOR, 0, 500);
    send_sample(CMD_MOTOR, 0, 16100);
    send_sample(CMD_MOTOR, 1, -329);
    send_sample(CMD_MOTOR, 1, -16384);
    send_sample(CMD_MOTOR, 2, 12000);
    send_sample(CMD_MOTOR, 3, -12000);
    send_sample(CMD_SERVO, 0, 16384);
    send_sample(CMD_SERVO, 1, -16384);
    send_sample(CMD_SERVO, 2, 0);
    send_sample(CMD_SERVO, 3, 8192);
    send_sample(CMD_SERVO, 3, 8000);
    settle_idle();

    // no dead zone, limits above one, min above max, pulse extremes, unknown index
    program_reg(CFG_ANTI_JITTER, '0);
    program_reg(CFG_M0_LIM_MIN, CFG_DATA_W'(LIM_TOP));
    program_reg(CFG_M0_LIM_MAX, CFG_DATA_W'(20000));
    program_reg(CFG_M1_LIM_MIN, CFG_DATA_W'(ONE_Q));
    program_reg(CFG_M1_LIM_MAX, '0);
    program_reg(CFG_PULSE_MIN, '0);
    program_reg(CFG_PULSE_MAX, '1);
    program_reg('1, {16'($urandom()), 32'($urandom())});
    cfg_valid <= 1'b0;
    aj_now = 0;
    send_sample(CMD_MOTOR, 0, 1);
    send_sample(CMD_MOTOR, 0, -1);
    send_sample(CMD_MOTOR, 1, 8192);
    send_sample(CMD_MOTOR, 1, -8192);
    send_sample(CMD_SERVO, 0, -16384);
    send_sample(CMD_SERVO, 1, 16384);
    send_sample(CMD_SERVO, 2, -1);

    for (int p = 0; p < 6; p++) begin
      settle_idle();
      settle_config(p % 3);
      if (p == 1) hold_req <= 1'b1;
      random_phase(82);
    end
    settle_idle();

    if (fail_total == 0 && awaiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: changing stall patterns, plus one long hold-off to back the block up
  initial begin : rx_side
    rx_mode_t mode;
    int       span;
    int       tick;
    bit       hold_spent;
    tick       = 0;
    hold_spent = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_req && !hold_spent) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          hold_spent = 1'b1;
        end
        case (mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready <= (tick % 4 == 0);
          default:     out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
